>>> hdl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types, widths and helpers of the feedback flanger delay unit.
// ----------------------------------------------------------------------------
package ffd_pkg;

  // sample and delay formats
  localparam int SB   = 16;             // sample width, signed Q1.15
  localparam int FB   = 8;              // fraction bits of the delay
  localparam int DAW  = 21;             // delay_amount width
  localparam int MDW  = 13;             // max_delay register width
  localparam int SUM_W = SB + 3;        // width of sums before saturation

  // stream packing
  localparam int IN_TDATA_W  = 40;      // SB + DAW, padded to whole bytes
  localparam int OUT_TDATA_W = SB;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY     = 1'd1;
  localparam logic [MDW-1:0]       MAX_DELAY_RESET   = 13'd8191;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // control and data handed to the arithmetic stage with the read data
  typedef struct packed {
    logic                 vld;
    logic                 err;
    logic                 fwd1;          // first tap is the entry being written
    logic                 fwd2;          // second tap is the entry being written
    logic [FB-1:0]        frac;
    logic signed [SB-1:0] sample;
  } stage2_t;

  // one result item
  typedef struct packed {
    logic                 err;
    logic signed [SB-1:0] sample;
  } res_t;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SB - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ffd_ram.sv
// ----------------------------------------------------------------------------
// ffd_ram
// Delay line storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ffd_ram
  import ffd_pkg::*;
#(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [SB-1:0] wdata,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic signed [SB-1:0] rdata_a_r,
  output logic signed [SB-1:0] rdata_b_r
);

  logic signed [SB-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

>>> hdl/ffd_arith.sv
// ----------------------------------------------------------------------------
// ffd_arith
// Feedback write value, linear interpolation and the last-output loop.
// ----------------------------------------------------------------------------
module ffd_arith
  import ffd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  stage2_t              s2,
  input  logic signed [SB-1:0] rd1,
  input  logic signed [SB-1:0] rd2,
  input  logic signed [SB-1:0] gain,
  output logic signed [SB-1:0] wr_data,
  output logic                 res_vld,
  output res_t                 res
);

  localparam int PROD_W = FB + SB + 2;

  logic signed [2*SB-1:0]   fbp_r, fbp_nxt;
  logic signed [SB-1:0]     lo_r, lo_nxt;
  logic                     s3_vld_r, s3_err_r;
  logic signed [SB-1:0]     b1_r, b1_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic signed [SB-1:0]     wval, b1, b2, y, fb_op;
  logic signed [SB:0]       diff;
  logic signed [SUM_W-1:0]  wsum, ysum;

  // stage 2: write value and interpolation product
  always_comb begin
    wsum     = SUM_W'(s2.sample) + SUM_W'($signed(fbp_r[2*SB-1:SB-1]));
    wval     = sat_sample(wsum);
    b1       = s2.fwd1 ? wval : rd1;
    b2       = s2.fwd2 ? wval : rd2;
    diff     = (SB+1)'(b2) - (SB+1)'(b1);
    prod_nxt = $signed({1'b0, s2.frac}) * diff;
    b1_nxt   = b1;
  end

  assign wr_data = wval;

  // stage 3: output sample, then the next feedback product
  always_comb begin
    ysum    = SUM_W'(b1_r) + SUM_W'($signed(prod_r[PROD_W-1:FB]));
    y       = sat_sample(ysum);
    lo_nxt  = (s3_vld_r && !s3_err_r) ? y : lo_r;
    fb_op   = lo_nxt;
    fbp_nxt = fb_op * gain;
  end

  assign res_vld    = s3_vld_r;
  assign res.err    = s3_err_r;
  assign res.sample = s3_err_r ? '0 : y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s3_err_r <= 1'b0;
      lo_r     <= '0;
      fbp_r    <= '0;
    end else begin
      s3_vld_r <= s2.vld;
      s3_err_r <= s2.err;
      lo_r     <= lo_nxt;
      fbp_r    <= fbp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_r   <= b1_nxt;
    prod_r <= prod_nxt;
  end

endmodule

>>> hdl/ffd_out_fifo.sv
// ----------------------------------------------------------------------------
// ffd_out_fifo
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
module ffd_out_fifo
  import ffd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_item,
  output logic rd_vld,
  input  logic rd_rdy,
  output res_t rd_item
);

  res_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  assign rd_vld  = (cnt_r != '0);
  assign rd_item = mem_r[rd_ptr_r];
  assign pop     = rd_vld && rd_rdy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !pop) begin
      cnt_nxt = cnt_r + OUT_CNT_W'(1);
    end else if (!wr_en && pop) begin
      cnt_nxt = cnt_r - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hdl/feedback_flanger_delay_unit.sv
// ----------------------------------------------------------------------------
// feedback_flanger_delay_unit
// Fractional delay line with feedback and linear interpolation (flanger core).
// ----------------------------------------------------------------------------
// Each input item carries a Q1.15 sample and a delay in samples with 8
// fraction bits. The unit writes sample + feedback_gain * last output into a
// circular line of max_delay+1 entries, reads the two entries the delay
// behind the write position and interpolates between them; the result is
// the output item and the next feedback source. A delay above max_delay gives
// a zero sample with delay_error set and leaves all state untouched. The unit
// takes a new item only after the last one has left stage 1; that spacing
// is set by the feedback loop, which runs through two register stages (write
// value and interpolation multiply, then output and the next feedback
// multiply). Results pass stage 1, stage 2, stage 3 and the result queue;
// at most 4 items may be outstanding in the pipeline and the queue before
// input is held off. After reset the line memory is cleared one entry per
// cycle and no item is accepted until the clear pass ends; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module feedback_flanger_delay_unit
  import ffd_pkg::*;
#(
  parameter int DEPTH = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [15:0] sample_in, [36:16] delay_amount, [39:37] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] sample_out
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] delay_error
  output logic [0:0]             out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;
  // width that holds both the delay and max_delay << FB
  localparam int CW = (DAW > AW + FB) ? DAW : AW + FB;
  localparam int PW = CW + 1;

  // configuration registers
  logic signed [SB-1:0] gain_r;
  logic [MDW-1:0]       maxd_r;

  // state
  logic [AW-1:0]        wp_r, wp_nxt;
  logic                 clr_act_r;
  logic [AW-1:0]        clr_addr_r;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;

  // stage 1: address generation
  logic                 s1_vld_r, s1_err_r;
  logic signed [SB-1:0] s1_sample_r;
  logic [DAW-1:0]       s1_delay_r;

  // stage 2: memory data returns
  stage2_t              s2_r, s2_nxt;
  logic [AW-1:0]        s2_wp_r;

  // line length from the clamped max_delay
  logic [AW-1:0]        md;
  logic [LW-1:0]        len;

  logic                 in_acc, out_acc;
  logic signed [SB-1:0] in_sample;
  logic [DAW-1:0]       in_delay;
  logic                 in_err;

  logic [AW-1:0]        wpe, v1, v2;
  logic [CW-1:0]        wp_sh;
  logic [PW-1:0]        len_sh, pos_raw, pos;
  logic [AW-1:0]        v1_inc;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [SB-1:0] mem_wdata, wr_val;
  logic signed [SB-1:0] rd1, rd2;

  logic                 res_vld, q_vld;
  res_t                 res, q_item;

  assign cfg_ready = 1'b1;

  // clamp max_delay into 1 .. DEPTH-1
  always_comb begin
    if (maxd_r == '0) begin
      md = AW'(1);
    end else if (32'(maxd_r) > 32'(DEPTH - 1)) begin
      md = AW'(DEPTH - 1);
    end else begin
      md = AW'(maxd_r);
    end
    len = LW'(md) + LW'(1);
  end

  // accept side: one item in stage 1 at a time, credits for the queue
  assign in_tready = !clr_act_r && !s1_vld_r && (cnt_r < OUT_CNT_W'(OUT_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = $signed(in_tdata[SB-1:0]);
  assign in_delay  = in_tdata[SB +: DAW];
  assign in_err    = CW'(in_delay) > (CW'(md) << FB);

  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + OUT_CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - OUT_CNT_W'(1);
    end
  end

  // stage 1: read position behind the write position, wrapped into the line
  always_comb begin
    wpe     = (LW'(wp_r) >= len) ? '0 : wp_r;
    wp_sh   = CW'(wpe) << FB;
    len_sh  = PW'(len) << FB;
    pos_raw = {1'b0, wp_sh} - {1'b0, CW'(s1_delay_r)};
    pos     = pos_raw[PW-1] ? (pos_raw + len_sh) : pos_raw;
    v1      = pos[FB +: AW];
    v1_inc  = v1 + AW'(1);
    v2      = (LW'(v1) + LW'(1) == len) ? '0 : v1_inc;

    s2_nxt.vld    = s1_vld_r;
    s2_nxt.err    = s1_err_r;
    s2_nxt.fwd1   = (v1 == wpe);
    s2_nxt.fwd2   = (v2 == wpe);
    s2_nxt.frac   = pos[FB-1:0];
    s2_nxt.sample = s1_sample_r;

    // advance the write position only for items that write
    wp_nxt = wp_r;
    if (s1_vld_r && !s1_err_r) begin
      wp_nxt = (LW'(wpe) + LW'(1) == len) ? '0 : wpe + AW'(1);
    end
  end

  // memory write: clear pass after reset, else the stage 2 write value
  always_comb begin
    mem_we    = clr_act_r || (s2_r.vld && !s2_r.err);
    mem_waddr = clr_act_r ? clr_addr_r : s2_wp_r;
    mem_wdata = clr_act_r ? '0 : wr_val;
  end

  ffd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .raddr_a   (v1),
    .raddr_b   (v2),
    .rdata_a_r (rd1),
    .rdata_b_r (rd2)
  );

  ffd_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .s2      (s2_r),
    .rd1     (rd1),
    .rd2     (rd2),
    .gain    (gain_r),
    .wr_data (wr_val),
    .res_vld (res_vld),
    .res     (res)
  );

  ffd_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld),
    .wr_item (res),
    .rd_vld  (q_vld),
    .rd_rdy  (out_tready),
    .rd_item (q_item)
  );

  assign out_tvalid   = q_vld;
  assign out_tdata    = q_item.sample;
  assign out_tuser[0] = q_item.err;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= '0;
      maxd_r     <= MAX_DELAY_RESET;
      wp_r       <= '0;
      clr_act_r  <= 1'b1;
      clr_addr_r <= '0;
      cnt_r      <= '0;
      s1_vld_r   <= 1'b0;
      s2_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEEDBACK_GAIN: gain_r <= $signed(cfg_data[SB-1:0]);
          REG_MAX_DELAY:     maxd_r <= cfg_data[MDW-1:0];
          default: begin
          end
        endcase
      end
      if (clr_act_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_act_r <= 1'b0;
        end
      end
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= in_acc;
      s2_r     <= s2_nxt;
    end
  end

  // payload of the first two stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r    <= in_err;
      s1_sample_r <= in_sample;
      s1_delay_r  <= in_delay;
    end
    s2_wp_r <= wpe;
  end

endmodule

>>> hdl/ffd_checker.sv
// ----------------------------------------------------------------------------
// ffd_checker
// Port-level checks of the feedback flanger delay unit, bound to the top.
// ----------------------------------------------------------------------------
module ffd_checker
  import ffd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser
);

  // an out-of-range delay yields a zero sample
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error item carries a nonzero sample");

  // the clear pass holds input off right after reset
  a_clear_hold: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during clear pass");

  // items are never accepted in consecutive cycles
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("items accepted in consecutive cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind feedback_flanger_delay_unit ffd_checker u_ffd_checker (.*);
